FILE: src/sse_pkg.sv
// Shared types and constants for the servo sweep with emergency stop core.
`default_nettype none
package sse_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_STEP     = 2'd1,
    CFG_MIN_PW   = 2'd2,
    CFG_MAX_PW   = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 32;

  localparam logic [31:0] DebounceRst = 32'd150000;
  localparam logic [6:0]  StepRst     = 7'd2;
  localparam logic [11:0] MinPwRst    = 12'd500;
  localparam logic [11:0] MaxPwRst    = 12'd2500;

  localparam logic [7:0]  AngleMax    = 8'd180;

  // x / 45 == (x * RecipMul) >> RecipShift, exact for x < 381300
  localparam logic [18:0] RecipMul    = 19'd372828;
  localparam int unsigned RecipShift  = 24;

  typedef struct packed {
    logic [31:0] debounce_us;
    logic [6:0]  step_degrees;
    logic [11:0] min_pulse_us;
    logic [11:0] max_pulse_us;
  } cfg_t;

  // Sweep state after an item
  typedef struct packed {
    logic [7:0] angle;
    logic       up;
    logic       alert;
  } sweep_t;

  // Stage load strobes for the pulse pipeline
  typedef struct packed {
    logic load2;
    logic load3;
  } pipe_ctl_t;

endpackage
`default_nettype wire

FILE: src/sse_update.sv
// Button edge/debounce handling and angle sweep state update.
`default_nettype none
module sse_update import sse_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        sample_i,
  input  wire logic        level_i,
  input  wire logic [31:0] time_i,
  input  wire logic        tick_i,
  input  wire cfg_t        cfg_i,
  output sweep_t           state_o
);

  sweep_t      state_q, state_d;
  logic        prev_q, prev_d;
  logic [31:0] last_q, last_d;

  logic [31:0]       gap;
  logic              alert_nx;
  logic signed [9:0] next_s;

  always_comb begin
    gap      = time_i - last_q;
    alert_nx = state_q.alert;
    prev_d   = prev_q;
    last_d   = last_q;
    if (sample_i) begin
      if (!level_i && prev_q && (gap > cfg_i.debounce_us)) begin
        alert_nx = 1'b1;
        last_d   = time_i;
      end
      if (level_i && !prev_q) begin
        alert_nx = 1'b0;
        last_d   = time_i;
      end
      prev_d = level_i;
    end

    state_d       = state_q;
    state_d.alert = alert_nx;
    if (state_q.up) begin
      next_s = $signed({2'b00, state_q.angle}) + $signed({3'b000, cfg_i.step_degrees});
    end else begin
      next_s = $signed({2'b00, state_q.angle}) - $signed({3'b000, cfg_i.step_degrees});
    end
    if (tick_i && !alert_nx) begin
      if (next_s >= $signed({2'b00, AngleMax})) begin
        state_d.angle = AngleMax;
        state_d.up    = 1'b0;
      end else if (next_s <= 10'sd0) begin
        state_d.angle = 8'd0;
        state_d.up    = 1'b1;
      end else begin
        state_d.angle = next_s[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{angle: 8'd0, up: 1'b1, alert: 1'b0};
      prev_q  <= 1'b1;
      last_q  <= 32'd0;
    end else if (en_i) begin
      state_q <= state_d;
      prev_q  <= prev_d;
      last_q  <= last_d;
    end
  end

  assign state_o = state_q;

endmodule
`default_nettype wire

FILE: src/sse_pulse.sv
// Two-stage pulse width pipeline: angle*span, then /180 by reciprocal plus min.
`default_nettype none
module sse_pulse import sse_pkg::*; (
  input  wire logic      clk_i,
  input  wire pipe_ctl_t ctl_i,
  input  wire sweep_t    state_i,
  input  wire cfg_t      cfg_i,
  output sweep_t         state_o,
  output logic [11:0]    pulse_o
);

  logic [11:0] span;
  logic [19:0] prod_d, prod_q;
  sweep_t      st2_q, st3_q;
  logic [17:0] quarter;
  logic [36:0] scaled;
  logic [11:0] pulse_d, pulse_q;

  always_comb begin
    span    = (cfg_i.max_pulse_us >= cfg_i.min_pulse_us) ?
              (cfg_i.max_pulse_us - cfg_i.min_pulse_us) : 12'd0;
    prod_d  = {12'd0, state_i.angle} * {8'd0, span};
    // /180 == (/4) then (/45)
    quarter = prod_q[19:2];
    scaled  = {19'd0, quarter} * {18'd0, RecipMul};
    pulse_d = cfg_i.min_pulse_us + scaled[RecipShift +: 12];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load2) begin
      prod_q <= prod_d;
      st2_q  <= state_i;
    end
    if (ctl_i.load3) begin
      pulse_q <= pulse_d;
      st3_q   <= st2_q;
    end
  end

  assign state_o = st3_q;
  assign pulse_o = pulse_q;

endmodule
`default_nettype wire

FILE: src/servo_sweep_with_emergency_stop_core.sv
// Top level of the servo sweep with emergency stop core.
`default_nettype none
// Servo sweep with emergency stop. Each request carries an optional sample of
// the active-low stop button (with a 32-bit microsecond timestamp) and an
// optional servo-period tick; exactly one result comes back per request, in
// order. A press (level 1->0) latches the alert only if the wrapped time since
// the last accepted button event exceeds debounce_us; a release (0->1) always
// clears it and records the time. A tick with no alert moves the angle by
// step_degrees, clamping and reversing at 0 and 180. The result holds the
// angle, pulse width min+angle*(max-min)/180 (truncated, span 0 if max<min),
// alert and direction.
// Throughput: one request per clock unless the output stalls. A request lands in
// the input register on the accepting edge, then passes the state update, the
// angle*span product and the reciprocal divide-by-180 into the output register.
// The sweep state update is the loop that sets the one-per-clock rate. A stage
// stalls only when every stage after it is full and the output register is not
// taken; bubbles close up, so requests are held off only while all four stages
// are full.
// Configuration: write enable, index 0..3 (debounce, step, min, max pulse),
// 32-bit data, taken on any clock; change it only while the core is idle.
module servo_sweep_with_emergency_stop_core import sse_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config write port
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // request channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                button_sample_i,
  input  wire logic                button_level_i,
  input  wire logic [31:0]         time_us_i,
  input  wire logic                servo_tick_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               angle_deg_o,
  output logic [11:0]              pulse_us_o,
  output logic                     alert_o,
  output logic                     moving_up_o
);

  cfg_t cfg_q;

  // Stage valids: 0 input reg, 1 sweep state, 2 product, 3 output reg
  logic v0_q, v1_q, v2_q, v3_q;
  logic load0, load1, load2, load3;

  // Input register payload
  logic        sample_q, level_q, tick_q;
  logic [31:0] time_q;

  sweep_t    sweep_st, out_st;
  pipe_ctl_t ctl;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{debounce_us: DebounceRst, step_degrees: StepRst,
                 min_pulse_us: MinPwRst, max_pulse_us: MaxPwRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: cfg_q.debounce_us  <= cfg_data_i[31:0];
        CFG_STEP:     cfg_q.step_degrees <= cfg_data_i[6:0];
        CFG_MIN_PW:   cfg_q.min_pulse_us <= cfg_data_i[11:0];
        CFG_MAX_PW:   cfg_q.max_pulse_us <= cfg_data_i[11:0];
        default:      ;
      endcase
    end
  end

  // Each stage loads when it is empty or its contents move on
  assign load3 = !v3_q || out_ready_i;
  assign load2 = !v2_q || load3;
  assign load1 = !v1_q || load2;
  assign load0 = !v0_q || load1;
  assign in_ready_o = load0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (load0) v0_q <= in_valid_i;
      if (load1) v1_q <= v0_q;
      if (load2) v2_q <= v1_q;
      if (load3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load0) begin
      sample_q <= button_sample_i;
      level_q  <= button_level_i;
      time_q   <= time_us_i;
      tick_q   <= servo_tick_i;
    end
  end

  // Sweep state is stage 1: it only advances for a real request
  sse_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (load1 && v0_q),
    .sample_i (sample_q),
    .level_i  (level_q),
    .time_i   (time_q),
    .tick_i   (tick_q),
    .cfg_i    (cfg_q),
    .state_o  (sweep_st)
  );

  assign ctl = '{load2: load2, load3: load3};

  sse_pulse u_pulse (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .state_i (sweep_st),
    .cfg_i   (cfg_q),
    .state_o (out_st),
    .pulse_o (pulse_us_o)
  );

  assign out_valid_o = v3_q;
  assign angle_deg_o = out_st.angle;
  assign alert_o     = out_st.alert;
  assign moving_up_o = out_st.up;

endmodule
`default_nettype wire

FILE: src/sse_checker.sv
// Port-level checks for the servo sweep core, bound to the top level.
`default_nettype none
module sse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  angle_deg_o,
  input wire logic [11:0] pulse_us_o,
  input wire logic        alert_o,
  input wire logic        moving_up_o
);

  // Stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_deg_o) &&
      $stable(pulse_us_o) && $stable(alert_o) && $stable(moving_up_o))
    else $error("result changed while stalled");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_deg_o <= 8'd180)
    else $error("angle above 180");

  // Ends of the sweep always point back inward
  a_end_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (angle_deg_o == 8'd180 || angle_deg_o == 8'd0) |->
      moving_up_o == (angle_deg_o == 8'd0))
    else $error("wrong direction at sweep end");

  // Requests are held off only by a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request blocked without output stall");

endmodule

bind servo_sweep_with_emergency_stop_core sse_checker u_sse_checker (.*);
`default_nettype wire
